[rtl/core/assert_macros.svh]
// assert_macros.svh: assertion macros used by the checker file fpe_checker.
// Clock and reset are taken from the clk and rst_n names in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define FPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication shorthand: when trigger holds, expect holds next cycle
`define FPE_ASSERT_NEXT(label, trig, expct, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expct)) \
    else $error(msg);

`endif

[rtl/core/fpe_pkg.sv]
// fpe_pkg: widths, codes and helpers of the frustum plane extractor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpe_pkg;

  localparam int COEF_W  = 32;   // Q16.16 coefficient
  localparam int ROOT_W  = 32;   // integer square root of 64-bit value
  localparam int SQ_W    = 64;   // squared normal length
  localparam int DVD_W   = 48;   // |coef| << 16
  localparam int IDX_W   = 4;
  localparam int PID_W   = 3;

  localparam logic [IDX_W-1:0] TRIGGER_IDX = 4'd15;
  localparam logic [PID_W-1:0] LAST_PLANE  = 3'd5;

  typedef logic signed [COEF_W-1:0] coef_t;

  // a + b or a - b, saturated to signed 32 bits
  function automatic coef_t sat_addsub(input coef_t a, input coef_t b, input logic sub);
    logic signed [COEF_W:0] s;
    begin
      s = sub ? ({a[COEF_W-1], a} - {b[COEF_W-1], b})
              : ({a[COEF_W-1], a} + {b[COEF_W-1], b});
      if (s[COEF_W] != s[COEF_W-1]) begin
        sat_addsub = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
        sat_addsub = s[COEF_W-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/fpe_ram.sv]
// fpe_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/fpe_sqrt.sv]
// fpe_sqrt: bit-pair restoring integer square root, one result bit a cycle.
// Depends on fpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpe_sqrt import fpe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_t, trial;
  logic              ge;

  // one trial subtract per cycle
  always_comb begin
    rem_t = {rem_r[REM_W-3:0], rad_r[SQ_W-1:SQ_W-2]};
    trial = {1'b0, root_r, 2'b01};
    ge    = (rem_t >= trial);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_t - trial) : rem_t;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      rad_nxt  = {rad_r[SQ_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

[rtl/core/fpe_div.sv]
// fpe_div: restoring unsigned divider, one quotient bit a cycle.
// Depends on fpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpe_div import fpe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [ROOT_W-1:0] divisor,
  output logic                   done,
  output logic [DVD_W-1:0]       quotient
);

  localparam int REM_W = ROOT_W + 1;
  localparam int CNT_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] dvs_r, dvs_nxt;
  logic [REM_W-1:0]  rem_t;
  logic              ge;

  // shift in one dividend bit, trial subtract
  always_comb begin
    rem_t = {rem_r[REM_W-2:0], quo_r[DVD_W-1]};
    ge    = (rem_t >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_t - {1'b0, dvs_r}) : rem_t;
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/core/frustum_plane_extract.sv]
// frustum_plane_extract: top level, sequencer around the matrix RAM,
// a shared multiplier, the square root unit and the divider.
// Depends on fpe_pkg, fpe_ram, fpe_sqrt, fpe_div.
//
//  channel | dir | tdata (low bit up)                        | tuser      | tlast
//  in_     | in  | element_index[3:0], element_value[35:4]   | -          | -
//  out_    | out | plane_id[2:0], normal_x, normal_y,        | degenerate | last_plane
//          |     | normal_z, plane_offset[130:99]            |            |
//
// An element other than 15 is stored; in_tready stays high. Index 15
// writes its element, then runs six planes, each with RAM reads and adds,
// three multiply/accumulates, a root and four divides (none for a zero root),
// bounded by the one-bit-per-cycle divider; in_tready is low meanwhile.
// A stalled result holds the sequencer. rst_n is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module frustum_plane_extract import fpe_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // element_index[3:0], element_value[35:4]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // plane_id[2:0], normal_x[34:3], normal_y[66:35],
                                        // normal_z[98:67], plane_offset[130:99]
  output logic              out_tuser,  // degenerate
  output logic              out_tlast   // last_plane
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDA  = 4'd1;
  localparam logic [3:0] ST_RDB  = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_SQS  = 4'd6;
  localparam logic [3:0] ST_SQW  = 4'd7;
  localparam logic [3:0] ST_DVS  = 4'd8;
  localparam logic [3:0] ST_DVW  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0]             state_r, state_nxt;
  logic [PID_W-1:0]       plane_r, plane_nxt;
  logic [1:0]             k_r, k_nxt;
  coef_t                  a_r;
  coef_t                  coef_r [4];
  coef_t                  norm_r [4];
  logic signed [SQ_W-1:0] prod_r;
  logic [SQ_W-1:0]        sq_r;
  logic [ROOT_W-1:0]      len_r;
  logic                   degen_r;

  logic                   in_acc;
  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       raddr;
  logic [COEF_W-1:0]      rdata;
  logic                   sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]      root;
  logic [DVD_W-1:0]       quo;
  coef_t                  cur;
  logic [COEF_W-1:0]      mag;
  coef_t                  qsat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IDX_W-1:0];

  // matrix element store
  fpe_ram #(.WIDTH(COEF_W), .DEPTH(16)) u_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (in_idx),
    .wdata (in_tdata[35:4]),
    .raddr (raddr),
    .rdata (rdata)
  );

  // row 3 in the a read, the plane's row in the b read
  assign raddr = (state_r == ST_RDB) ? {k_r, plane_r[2:1]} : {k_r, 2'd3};

  assign sq_start = (state_r == ST_SQS);
  assign dv_start = (state_r == ST_DVS);
  assign cur      = coef_r[k_r];
  assign mag      = cur[COEF_W-1] ? (-cur) : cur;

  fpe_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_r),
    .done     (sq_done),
    .root     (root)
  );

  fpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend ({mag, 16'h0000}),
    .divisor  (len_r),
    .done     (dv_done),
    .quotient (quo)
  );

  // sign and saturate the quotient magnitude
  always_comb begin
    if (cur[COEF_W-1]) begin
      if (quo > DVD_W'(48'h0000_8000_0000)) begin
        qsat = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
        qsat = -coef_t'(quo[COEF_W-1:0]);
      end
    end else begin
      if (quo > DVD_W'(48'h0000_7FFF_FFFF)) begin
        qsat = {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
        qsat = quo[COEF_W-1:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_idx == TRIGGER_IDX)) begin
          state_nxt = ST_RDA;
          plane_nxt = '0;
          k_nxt     = '0;
        end
      end
      ST_RDA: state_nxt = ST_RDB;
      ST_RDB: state_nxt = ST_SUM;
      ST_SUM: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 2'd3) ? ST_MUL : ST_RDA;
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (k_r == 2'd2) begin
          k_nxt     = '0;
          state_nxt = ST_SQS;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_SQS: state_nxt = ST_SQW;
      ST_SQW: begin
        if (sq_done) begin
          state_nxt = (root == '0) ? ST_OUT : ST_DVS;
        end
      end
      ST_DVS: state_nxt = ST_DVW;
      ST_DVW: begin
        if (dv_done) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r == 2'd3) ? ST_OUT : ST_DVS;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          k_nxt = '0;
          if (plane_r == LAST_PLANE) begin
            state_nxt = ST_IDLE;
          end else begin
            plane_nxt = plane_r + 1'b1;
            state_nxt = ST_RDA;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      plane_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      k_r     <= k_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_RDB) begin
      a_r <= rdata;
    end
    if (state_r == ST_SUM) begin
      coef_r[k_r] <= sat_addsub(a_r, rdata, plane_r[0]);
    end
    if (state_r == ST_MUL) begin
      prod_r <= cur * cur;
    end
    // clear the squared length while the plane's elements are read
    if (state_r == ST_RDA) begin
      sq_r <= '0;
    end else if (state_r == ST_ACC) begin
      sq_r <= sq_r + prod_r;
    end
    if ((state_r == ST_SQW) && sq_done) begin
      len_r   <= root;
      degen_r <= (root == '0);
      if (root == '0) begin
        for (int i = 0; i < 4; i++) begin
          norm_r[i] <= '0;
        end
      end
    end
    if ((state_r == ST_DVW) && dv_done) begin
      norm_r[k_r] <= qsat;
    end
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'd0, norm_r[3], norm_r[2], norm_r[1], norm_r[0], plane_r};
  assign out_tuser  = degen_r;
  assign out_tlast  = (plane_r == LAST_PLANE);

endmodule

`default_nettype wire

[rtl/core/fpe_checker.sv]
// fpe_checker: port-level assertions for frustum_plane_extract, bound in.
// Depends on assert_macros.svh and fpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpe_checker import fpe_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [39:0]  in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata,
  input wire logic         out_tuser,
  input wire logic         out_tlast
);

  logic         in_acc;
  logic         is_trig;
  logic         out_stall;
  logic         coef_zero;
  logic [137:0] out_all;

  assign in_acc    = in_tvalid && in_tready;
  assign is_trig   = (in_tdata[IDX_W-1:0] == TRIGGER_IDX);
  assign out_stall = out_tvalid && !out_tready;
  assign coef_zero = (out_tdata[130:3] == '0);
  assign out_all   = {out_tdata, out_tuser, out_tlast};

  // a stalled result holds
  `FPE_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_all), "stalled result changed")
  // no element taken while a plane is shown
  `FPE_ASSERT(a_no_overlap, !(out_tvalid && in_tready), "input ready during output")
  // a degenerate plane carries zero coefficients
  `FPE_ASSERT(a_degen_zero, !(out_tvalid && out_tuser) || coef_zero, "degenerate not zero")
  // the trigger element starts the busy period
  `FPE_ASSERT_NEXT(a_trig_busy, in_acc && is_trig, !in_tready, "ready after trigger")
  // plain elements leave the block ready
  `FPE_ASSERT_NEXT(a_load_ready, in_acc && !is_trig, in_tready, "not ready after load")

endmodule

bind frustum_plane_extract fpe_checker u_fpe_checker (.*);

`default_nettype wire

[tb/frustum_plane_checker.sv]
// frustum_plane_checker: watches both channels of frustum_plane_extract, keeps its own
// copy of the matrix, predicts the six normalized planes and compares them in order.
// Depends on fpe_pkg only for the trigger index.
`timescale 1ns / 1ps

module frustum_plane_checker import fpe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           planes_pending
);

  typedef struct packed {
    logic [2:0]         pid;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] off;
    logic               degen;
    logic               last;
  } plane_t;

  logic signed [31:0] mat[16];
  plane_t             plane_q[$];

  assign planes_pending = plane_q.size();

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // bitwise integer square root of a 64-bit value
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // all six planes from the current matrix
  task automatic predict_planes();
    logic signed [31:0] c[4];
    logic signed [63:0] a, b, q;
    logic [63:0]        sq, len;
    plane_t             pl;
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 4; k++) begin
        a = mat[k*4+3];
        b = mat[k*4+(p>>1)];
        c[k] = clamp32(p[0] ? a - b : a + b);
      end
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        a = c[k];
        sq = sq + 64'(a * a);
      end
      len = root64(sq);
      pl = '0;
      pl.pid = p[2:0];
      pl.last = (p == 5);
      if (len == 0) begin
        pl.degen = 1'b1;
      end else begin
        q = (64'(c[0]) <<< 16) / $signed(len); pl.nx = clamp32(q);
        q = (64'(c[1]) <<< 16) / $signed(len); pl.ny = clamp32(q);
        q = (64'(c[2]) <<< 16) / $signed(len); pl.nz = clamp32(q);
        q = (64'(c[3]) <<< 16) / $signed(len); pl.off = clamp32(q);
      end
      plane_q.push_back(pl);
    end
  endtask

  always @(posedge clk) begin
    plane_t exp_pl, got;
    if (!rst_n) begin
      fail_count <= 0;
      for (int i = 0; i < 16; i++) mat[i] = 0;
    end else begin
      // input request: store element, trigger on index 15
      if (in_tvalid && in_tready) begin
        mat[in_tdata[3:0]] = in_tdata[35:4];
        if (in_tdata[3:0] == TRIGGER_IDX) predict_planes();
      end
      // result request
      if (out_tvalid && out_tready) begin
        got = {out_tdata[2:0], out_tdata[34:3], out_tdata[66:35], out_tdata[98:67],
               out_tdata[130:99], out_tuser, out_tlast};
        if (plane_q.size() == 0) begin
          $display("%0t unexpected plane %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_pl = plane_q.pop_front();
          if (got !== exp_pl) begin
            $display("%0t plane mismatch expected pid=%0d x=%h y=%h z=%h w=%h dg=%b l=%b",
                     $time, exp_pl.pid, exp_pl.nx, exp_pl.ny, exp_pl.nz, exp_pl.off,
                     exp_pl.degen, exp_pl.last);
            $display("%0t              actual   pid=%0d x=%h y=%h z=%h w=%h dg=%b l=%b",
                     $time, got.pid, got.nx, got.ny, got.nz, got.off, got.degen, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/frustum_plane_extract_tb.sv]
// frustum_plane_extract_tb: drives matrices into frustum_plane_extract under several
// idling phases and gives the verdict. Depends on fpe_pkg, the block and the checker.
`timescale 1ns / 1ps

module frustum_plane_extract_tb;
  import fpe_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [135:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           planes_pending;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  frustum_plane_extract u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  frustum_plane_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .planes_pending
  );

  // receiver: random stalls, or a long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any request
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one element request, with random gaps before it
  task automatic send_elem(input logic [3:0] idx, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_done();
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(262144)) - 131072);
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // whole matrix in shuffled order with index 15 last, some rewrites mixed in
  task automatic send_matrix();
    int ord[15];
    for (int i = 0; i < 15; i++) ord[i] = i;
    ord.shuffle();
    foreach (ord[i]) begin
      send_elem(4'(ord[i]), rand_val());
      if ($urandom_range(9) == 0) send_elem(4'($urandom_range(14)), rand_val());
    end
    send_elem(TRIGGER_IDX, rand_val());
  endtask

  // the checker queues its prediction on the trigger edge, so look only after that edge
  task automatic drain();
    send_done();
    @(posedge clk);
    while (planes_pending != 0) @(posedge clk);
  endtask

  initial begin
    int sent_mats;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, zero matrix (all degenerate), extremes
    for (int i = 0; i < 16; i++) send_elem(4'(i), (i % 5 == 0) ? 32'h10000 : 32'h0);
    for (int i = 0; i < 16; i++) send_elem(4'(i), 32'h0);
    drain();
    for (int i = 0; i < 16; i++) send_elem(4'(i), i[0] ? 32'h80000000 : 32'h7fffffff);
    send_elem(TRIGGER_IDX, 32'hffffffff);

    // random matrices over idling phases, about 380 elements
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 26) : 0;
      recv_stall_pct = (ph == 2) ? 65 : (ph == 3 ? 26 : 0);
      for (sent_mats = 0; sent_mats < 5; sent_mats++) send_matrix();
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
          begin repeat (3000) @(posedge clk); hold_off = 0; end
          send_matrix();
        join
        drain();
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
